[hdl/fixed_point_arith_unit_core_defines.svh]
// Assertion macros shared by the fixed-point unit checker.
`ifndef FIXED_POINT_ARITH_UNIT_CORE_DEFINES_SVH
`define FIXED_POINT_ARITH_UNIT_CORE_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define FPA_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fpa check failed");
// Next-cycle implication checked outside reset.
`define FPA_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("fpa check failed");
`endif

[hdl/fpa_pkg.sv]
// Package with action codes and pipeline types of the fixed-point unit.
`default_nettype none
package fpa_pkg;
    typedef enum logic [3:0] {
        ACT_FIXMUL   = 4'd0,
        ACT_FIXDIV   = 4'd1,
        ACT_FRACMUL  = 4'd2,
        ACT_FRACDIV  = 4'd3,
        ACT_FRACSQRT = 4'd4,
        ACT_INT2FIX  = 4'd5,
        ACT_FIX2INT  = 4'd6,
        ACT_FIX2FRAC = 4'd7,
        ACT_FRAC2FIX = 4'd8
    } t_action;

    localparam int unsigned DivBits  = 62;
    localparam int unsigned SqrtBits = 31;

    // Result with saturation flag, produced by the multiply, divide and conversion lanes.
    typedef struct packed {
        logic [31:0] result;
        logic        saturated;
    } t_res;

    localparam logic [31:0] S32Max = 32'h7FFF_FFFF;
    localparam logic [31:0] S32Min = 32'h8000_0000;
endpackage
`default_nettype wire

[hdl/fpa_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with clamping.
`default_nettype none
module fpa_div
    import fpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic              i_frac,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output t_res                   o_res
);
    // Numerator magnitude |a|<<30 fits 62 bits; quotient needs up to 62 bits.
    logic [DivBits-1:0] r_num [DivBits+1];
    logic [DivBits-1:0] r_quo [DivBits+1];
    logic [32:0]        r_rem [DivBits+1];
    logic [31:0]        r_den [DivBits+1];
    logic               r_neg [DivBits+1];
    logic               r_dz  [DivBits+1];
    logic               r_an  [DivBits+1];
    logic [DivBits-1:0] w_mag;
    logic [31:0]        w_bm;
    logic [64:0]        w_q;

    always_comb begin
        w_mag = i_frac ? {{(DivBits-32){i_a[31]}}, i_a} <<< 30
                       : {{(DivBits-32){i_a[31]}}, i_a} <<< 16;
        if (i_a[31]) w_mag = -w_mag;
        w_bm = i_b[31] ? -i_b : i_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= w_mag;
            r_quo[0] <= '0;
            r_rem[0] <= '0;
            r_den[0] <= w_bm;
            r_neg[0] <= i_a[31] ^ i_b[31];
            r_dz[0]  <= (i_b == 32'sd0);
            r_an[0]  <= i_a[31];
        end
    end

    for (genvar s = 0; s < DivBits; s++) begin : g_st
        logic [33:0] w_sh;
        logic [33:0] w_df;
        always_comb begin
            w_sh = {r_rem[s], r_num[s][DivBits-1]};
            w_df = w_sh - {2'b00, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s+1] <= r_num[s] << 1;
                r_quo[s+1] <= {r_quo[s][DivBits-2:0], ~w_df[33]};
                r_rem[s+1] <= w_df[33] ? w_sh[32:0] : w_df[32:0];
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                r_dz[s+1]  <= r_dz[s];
                r_an[s+1]  <= r_an[s];
            end
        end
    end

    always_comb begin
        w_q = {3'b000, r_quo[DivBits]};
        if (r_neg[DivBits]) w_q = -w_q;
        o_res.saturated = 1'b0;
        o_res.result    = w_q[31:0];
        if (r_dz[DivBits]) begin
            o_res.saturated = 1'b1;
            o_res.result    = r_an[DivBits] ? S32Min : S32Max;
        end else if (!w_q[64] && w_q[63:31] != '0) begin
            o_res.saturated = 1'b1;
            o_res.result    = S32Max;
        end else if (w_q[64] && w_q[63:31] != '1) begin
            o_res.saturated = 1'b1;
            o_res.result    = S32Min;
        end
    end
endmodule
`default_nettype wire

[hdl/fpa_sqrt.sv]
// Pipelined digit-by-digit square root of a << 30, one result bit per stage.
`default_nettype none
module fpa_sqrt
    import fpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic signed [31:0] i_a,
    output logic [31:0]            o_root
);
    logic [61:0] r_rad [SqrtBits+1];
    logic [32:0] r_rem [SqrtBits+1];
    logic [30:0] r_rt  [SqrtBits+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0] <= i_a[31] ? '0 : {1'b0, i_a[30:0], 30'd0};
            r_rem[0] <= '0;
            r_rt[0]  <= '0;
        end
    end

    for (genvar s = 0; s < SqrtBits; s++) begin : g_st
        logic [34:0] w_tr;
        logic [34:0] w_df;
        always_comb begin
            w_tr = {r_rem[s], r_rad[s][61:60]};
            w_df = w_tr - {2'b00, r_rt[s], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s+1] <= r_rad[s] << 2;
                r_rt[s+1]  <= {r_rt[s][29:0], ~w_df[34]};
                r_rem[s+1] <= w_df[34] ? w_tr[32:0] : w_df[32:0];
            end
        end
    end

    assign o_root = {1'b0, r_rt[SqrtBits]};
endmodule
`default_nettype wire

[hdl/fpa_mul.sv]
// Two-stage signed multiplier with scaling shift and clamp, then a delay line.
`default_nettype none
module fpa_mul
    import fpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic              i_frac,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output t_res                   o_res
);
    localparam int unsigned Delay = DivBits;
    logic signed [63:0] r_p;
    logic               r_frac;
    logic signed [63:0] w_adj;
    logic signed [63:0] w_q;
    t_res               w_res;
    t_res               r_d [Delay];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= i_a * i_b;
            r_frac <= i_frac;
        end
    end

    // Truncation toward zero: bias negatives before the arithmetic shift.
    always_comb begin
        if (r_frac) begin
            w_adj = r_p + (r_p[63] ? 64'sd1073741823 : 64'sd0);
            w_q   = w_adj >>> 30;
        end else begin
            w_adj = r_p + (r_p[63] ? 64'sd65535 : 64'sd0);
            w_q   = w_adj >>> 16;
        end
        w_res.result    = w_q[31:0];
        w_res.saturated = 1'b0;
        if (!w_q[63] && w_q[62:31] != '0) begin
            w_res.result = S32Max; w_res.saturated = 1'b1;
        end else if (w_q[63] && w_q[62:31] != '1) begin
            w_res.result = S32Min; w_res.saturated = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= w_res;
            for (int k = 1; k < Delay; k++) r_d[k] <= r_d[k-1];
        end
    end

    assign o_res = r_d[Delay-1];
endmodule
`default_nettype wire

[hdl/fixed_point_arith_unit_core.sv]
// Top level of the pipelined 16.16 / 2.30 fixed-point arithmetic unit.
// Every beat on the slave side yields exactly one beat on the master side,
// in order. The unit is a pipeline of 64 stages: a beat can enter every
// cycle unless the master side stalls, so throughput is one beat per
// clock. The divider sets the depth, resolving one quotient bit per stage
// over 62 stages. Multiply, square root and the shift conversions run in
// parallel lanes padded to the same depth, and a final select stage picks
// the lane. The whole pipeline advances only when its last stage is free
// or drained, so a stall on the master side freezes every item in place.
`default_nettype none
module fixed_point_arith_unit_core
    import fpa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
    input  wire logic [3:0]  s_axis_tuser,   // action[3:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // result[31:0]
    output logic [0:0]       m_axis_tuser    // saturated[0]
);
    localparam int unsigned Depth = DivBits + 1;

    logic               r_vld [Depth];
    logic [3:0]         r_act [Depth];
    t_res               r_sim [Depth];
    logic               w_en;
    logic signed [31:0] w_a, w_b;
    logic               w_mfrac, w_dfrac;
    t_res               w_mul, w_div, w_sim;
    logic [31:0]        w_root;
    logic [31:0]        r_root_d;
    logic               r_ov;
    t_res               r_out;
    logic [47:0]        w_i2f;

    // Advance when the output register is empty or being drained.
    assign w_en = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_a = s_axis_tdata[31:0];
    assign w_b = s_axis_tdata[63:32];
    assign w_mfrac = (s_axis_tuser == ACT_FRACMUL);
    assign w_dfrac = (s_axis_tuser == ACT_FRACDIV);

    // The shift and conversion actions are computed at entry and ride along.
    always_comb begin
        w_i2f = {{16{w_a[31]}}, w_a} << 16;
        w_sim = '0;
        unique case (s_axis_tuser)
            ACT_INT2FIX: begin
                w_sim.result = w_i2f[31:0];
                if (w_i2f[47:31] != '0 && w_i2f[47:31] != '1) begin
                    w_sim.saturated = 1'b1;
                    w_sim.result    = w_a[31] ? S32Min : S32Max;
                end
            end
            ACT_FIX2INT:  w_sim.result = w_a >>> 16;
            ACT_FIX2FRAC: w_sim.result = w_a << 14;
            ACT_FRAC2FIX: w_sim.result = w_a >>> 14;
            default:      w_sim = '0;
        endcase
    end

    fpa_mul u_mul (.i_clk, .i_en(w_en), .i_frac(w_mfrac), .i_a(w_a), .i_b(w_b),
                   .o_res(w_mul));
    fpa_div u_div (.i_clk, .i_en(w_en), .i_frac(w_dfrac), .i_a(w_a), .i_b(w_b),
                   .o_res(w_div));
    fpa_sqrt u_sqrt (.i_clk, .i_en(w_en), .i_a(w_a), .o_root(w_root));

    // Root is ready after 32 stages; delay it to the common depth.
    logic [31:0] r_rd [Depth-SqrtBits-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rd[0] <= w_root;
            for (int k = 1; k < Depth-SqrtBits-1; k++) r_rd[k] <= r_rd[k-1];
        end
    end
    assign r_root_d = r_rd[Depth-SqrtBits-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Depth; k++) r_vld[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < Depth; k++) r_vld[k] <= r_vld[k-1];
            r_ov <= r_vld[Depth-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_act[0] <= s_axis_tuser;
            r_sim[0] <= w_sim;
            for (int k = 1; k < Depth; k++) begin
                r_act[k] <= r_act[k-1];
                r_sim[k] <= r_sim[k-1];
            end
            unique case (r_act[Depth-1])
                ACT_FIXMUL, ACT_FRACMUL: r_out <= w_mul;
                ACT_FIXDIV, ACT_FRACDIV: r_out <= w_div;
                ACT_FRACSQRT: r_out <= '{result: r_root_d, saturated: 1'b0};
                default:      r_out <= r_sim[Depth-1];
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out.result;
    assign m_axis_tuser  = r_out.saturated;
endmodule
`default_nettype wire

[hdl/fpa_checker.sv]
// Port-level checker for the fixed-point unit, bound to the top level.
`default_nettype none
`include "fixed_point_arith_unit_core_defines.svh"
module fpa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);
    `FPA_ASSERT_IMP(a_ready_when_free, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    `FPA_ASSERT_IMP(a_stall_blocks, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `FPA_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `FPA_ASSERT_IMP(a_sat_limit, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000)
endmodule

bind fixed_point_arith_unit_core fpa_checker u_chk (.*);
`default_nettype wire
